@@ src/wsdf_pkg.sv @@
`default_nettype none

package wsdf_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned LEN_W   = 64;
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned CNT_W   = 4;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [3:0] OP_BINARY   = 4'd2;
    localparam logic [3:0] OP_CLOSE    = 4'd8;

    localparam logic [CNT_W-1:0] EXT16_BYTES = 4'd2;
    localparam logic [CNT_W-1:0] EXT64_BYTES = 4'd8;
    localparam logic [CNT_W-1:0] KEY_BYTES   = 4'd4;

    typedef enum logic [KIND_W-1:0] {
        EV_BYTE  = 2'd0,
        EV_EMPTY = 2'd1,
        EV_CLOSE = 2'd2
    } event_kind_t;

endpackage

`default_nettype wire

@@ src/websocket_frame_deframer_unit.sv @@
// WebSocket deframer: takes the received stream one byte per transfer on the
// s_ side and gives binary payload bytes (unmasked), an empty-message event for
// an empty binary frame and a close event at the end of a close frame on the
// m_ side; other opcodes and FIN are ignored. One byte is taken every cycle
// while the output keeps up; a byte is registered on entry, runs through the
// combinational header/payload phase logic and lands in the output register,
// so a result reaches the m_ side through the input and output registers, and
// a stall on the m_ side can hold it between them. Each byte takes a single
// phase update, including a 64-bit length decrement.
`default_nettype none

module websocket_frame_deframer_unit
    import wsdf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] s_tdata,   // [7:0] stream_byte
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [BYTE_W-1:0]      m_tdata,   // [7:0] payload_byte
    output logic [KIND_W-1:0]      m_tuser,   // [1:0] event_kind
    output logic                   m_tlast    // message_end
);

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    // input stage
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_data_reg;
    logic              consume;

    // parser state
    phase_t            phase_reg, phase_next;
    logic [3:0]        opcode_reg, opcode_next;
    logic              masked_reg, masked_next;
    logic [LEN_W-1:0]  remain_reg, remain_next;
    logic [CNT_W-1:0]  hcount_reg, hcount_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [1:0]        key_idx_reg, key_idx_next;

    // result stage
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_data_reg;
    event_kind_t       out_kind_reg;
    logic              out_last_reg;

    logic              res_valid;
    logic [BYTE_W-1:0] res_data;
    event_kind_t       res_kind;
    logic              res_last;

    logic [BYTE_W-1:0] b;
    logic [6:0]        len_code;
    logic [LEN_W-1:0]  len_val;
    logic [CNT_W-1:0]  hcount_dec;
    logic [LEN_W-1:0]  remain_dec;
    logic [BYTE_W-1:0] key_byte;
    logic              len_known;
    logic              hdr_done;

    assign consume  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || consume;

    assign b          = in_data_reg;
    assign len_code   = b[6:0];
    assign hcount_dec = hcount_reg - 1'b1;
    assign remain_dec = remain_reg - 1'b1;
    assign key_byte   = BYTE_W'(key_reg >> {~key_idx_reg, 3'b000});

    always_comb
    begin
        phase_next   = phase_reg;
        opcode_next  = opcode_reg;
        masked_next  = masked_reg;
        remain_next  = remain_reg;
        hcount_next  = hcount_reg;
        key_next     = key_reg;
        key_idx_next = key_idx_reg;
        res_valid    = 1'b0;
        res_data     = '0;
        res_kind     = EV_BYTE;
        res_last     = 1'b1;
        len_known    = 1'b0;
        hdr_done     = 1'b0;
        len_val      = remain_reg;

        case (phase_reg)
            PH_HDR1:
            begin
                masked_next = b[7];
                if (len_code == LEN_CODE_16 || len_code == LEN_CODE_64)
                begin
                    hcount_next = (len_code == LEN_CODE_16) ? EXT16_BYTES : EXT64_BYTES;
                    remain_next = '0;
                    phase_next  = PH_EXTLEN;
                end
                else
                begin
                    len_val   = LEN_W'(len_code);
                    len_known = 1'b1;
                end
            end
            PH_EXTLEN:
            begin
                len_val     = {remain_reg[LEN_W-BYTE_W-1:0], b};
                remain_next = len_val;
                hcount_next = hcount_dec;
                len_known   = (hcount_dec == '0);
            end
            PH_KEY:
            begin
                key_next    = {key_reg[KEY_W-BYTE_W-1:0], b};
                hcount_next = hcount_dec;
                hdr_done    = (hcount_dec == '0);
            end
            PH_PAYLOAD:
            begin
                key_idx_next = key_idx_reg + 1'b1;
                remain_next  = remain_dec;
                if (remain_dec == '0)
                    phase_next = PH_HDR0;
                if (opcode_reg == OP_BINARY)
                begin
                    res_valid = 1'b1;
                    res_kind  = EV_BYTE;
                    res_data  = masked_reg ? (b ^ key_byte) : b;
                    res_last  = (remain_dec == '0);
                end
                else if (opcode_reg == OP_CLOSE && remain_dec == '0)
                begin
                    res_valid = 1'b1;
                    res_kind  = EV_CLOSE;
                end
            end
            default:
            begin
                opcode_next  = b[3:0];
                masked_next  = 1'b0;
                remain_next  = '0;
                hcount_next  = '0;
                key_idx_next = '0;
                phase_next   = PH_HDR1;
            end
        endcase

        if (len_known)
        begin
            remain_next = len_val;
            if (masked_next)
            begin
                hcount_next = KEY_BYTES;
                key_next    = '0;
                phase_next  = PH_KEY;
            end
            else
                hdr_done = 1'b1;
        end

        if (hdr_done)
        begin
            key_idx_next = '0;
            if (remain_next != '0)
                phase_next = PH_PAYLOAD;
            else
            begin
                phase_next = PH_HDR0;
                if (opcode_reg == OP_BINARY)
                begin
                    res_valid = 1'b1;
                    res_kind  = EV_EMPTY;
                end
                else if (opcode_reg == OP_CLOSE)
                begin
                    res_valid = 1'b1;
                    res_kind  = EV_CLOSE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HDR0;
            opcode_reg    <= '0;
            masked_reg    <= 1'b0;
            remain_reg    <= '0;
            hcount_reg    <= '0;
            key_reg       <= '0;
            key_idx_reg   <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (consume)
            begin
                out_valid_reg <= res_valid;
                phase_reg     <= phase_next;
                opcode_reg    <= opcode_next;
                masked_reg    <= masked_next;
                remain_reg    <= remain_next;
                hcount_reg    <= hcount_next;
                key_reg       <= key_next;
                key_idx_reg   <= key_idx_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_data_reg <= s_tdata;
        if (consume && res_valid)
        begin
            out_data_reg <= res_data;
            out_kind_reg <= res_kind;
            out_last_reg <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // payload phase is only entered with bytes left to consume
    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> remain_reg != '0)
        else $error("payload phase with zero bytes remaining");

    a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_EXTLEN || phase_reg == PH_KEY) |->
            (hcount_reg != '0 && hcount_reg <= EXT64_BYTES))
        else $error("header byte count out of range");

    a_event_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != EV_BYTE) |-> (m_tlast && m_tdata == '0))
        else $error("event result without end mark or with data");

    a_no_result_in_header: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && (phase_reg == PH_HDR0 || phase_reg == PH_EXTLEN) && !len_known)
            |=> !m_tvalid)
        else $error("result produced mid-header");

    a_key_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && phase_reg == PH_KEY && hdr_done) |=> key_idx_reg == '0)
        else $error("key index not cleared at end of header");

endmodule

`default_nettype wire
